// ----- rtl/tfcr_pkg.sv -----
// ----------------------------------------------------------------------------
// tfcr_pkg
// shared widths, opcodes, copy indexes and the disc command type of the
// toroidal filled circle raster
// ----------------------------------------------------------------------------
`default_nettype none

package tfcr_pkg;

  // item field widths
  localparam int OP_W     = 2;
  localparam int COORD_W  = 12;
  localparam int READ_W   = 9;
  localparam int RADIUS_W = 16;
  localparam int VALUE_W  = 16;
  localparam int FRAC_W   = 8;

  // grid counters hold the grid size itself, centres of copies are signed
  localparam int CNT_W  = COORD_W + 1;
  localparam int CEN_W  = COORD_W + 2;
  localparam int SPAN_W = CEN_W + 1;
  localparam int PROD_W = 2 * CNT_W;

  // default grid
  localparam int GRID_WIDTH_DEF  = 512;
  localparam int GRID_HEIGHT_DEF = 512;

  // opcodes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // copies of a disc per axis: the centre, shifted up one period, shifted down
  localparam int COPY_N = 3;
  localparam int COPY_W = $clog2(COPY_N);
  localparam logic [COPY_W-1:0] COPY_BASE = COPY_W'(0);
  localparam logic [COPY_W-1:0] COPY_LO   = COPY_W'(1);
  localparam logic [COPY_W-1:0] COPY_HI   = COPY_W'(COPY_N - 1);

  typedef struct packed {
    logic signed [CEN_W-1:0] cx;
    logic signed [CEN_W-1:0] cy;
    logic [RADIUS_W-1:0]     rq;
    logic [VALUE_W-1:0]      val;
  } disc_t;

endpackage

`default_nettype wire

// ----- rtl/tfcr_ram.sv -----
// ----------------------------------------------------------------------------
// tfcr_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tfcr_ram #(
  parameter int WIDTH = tfcr_pkg::VALUE_W,
  parameter int DEPTH = tfcr_pkg::GRID_WIDTH_DEF * tfcr_pkg::GRID_HEIGHT_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tfcr_modred.sv -----
// ----------------------------------------------------------------------------
// tfcr_modred
// reduces two coordinates modulo the grid size by reciprocal multiplication
// ----------------------------------------------------------------------------
`default_nettype none

module tfcr_modred #(
  parameter int MOD_A = tfcr_pkg::GRID_WIDTH_DEF,
  parameter int MOD_B = tfcr_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tfcr_pkg::COORD_W-1:0] a_i,
  input  wire logic [tfcr_pkg::COORD_W-1:0] b_i,
  output logic                              done_o,
  output logic      [tfcr_pkg::COORD_W-1:0] rem_a_o,
  output logic      [tfcr_pkg::COORD_W-1:0] rem_b_o
);

  localparam int CW   = tfcr_pkg::COORD_W;
  localparam int MW   = tfcr_pkg::CNT_W;
  localparam int SH   = 2 * CW;
  localparam int PR_W = CW + SH;
  localparam int QM_W = CW + MW;

  // reciprocals scaled by 2^SH, the quotient estimate is at most one low
  localparam logic [SH-1:0] RCP_A = SH'((2 ** SH) / MOD_A);
  localparam logic [SH-1:0] RCP_B = SH'((2 ** SH) / MOD_B);
  localparam logic [MW-1:0] M_A   = MW'(MOD_A);
  localparam logic [MW-1:0] M_B   = MW'(MOD_B);

  logic [2:0]      stg_q;
  logic [CW-1:0]   a_q, b_q, qa_q, qb_q, ra_q, rb_q;
  logic [PR_W-1:0] pa, pb;
  logic [QM_W-1:0] qma, qmb;
  logic [CW-1:0]   ca, cb;

  assign pa  = PR_W'(a_q) * PR_W'(RCP_A);
  assign pb  = PR_W'(b_q) * PR_W'(RCP_B);
  assign qma = QM_W'(qa_q) * QM_W'(M_A);
  assign qmb = QM_W'(qb_q) * QM_W'(M_B);
  assign ca  = a_q - qma[CW-1:0];
  assign cb  = b_q - qmb[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else begin
      stg_q <= {stg_q[1:0], start_i};
    end
  end

  // capture, quotient estimate, then remainder with one conditional subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (stg_q[0]) begin
      qa_q <= pa[PR_W-1:SH];
      qb_q <= pb[PR_W-1:SH];
    end
    if (stg_q[1]) begin
      ra_q <= ({1'b0, ca} >= M_A) ? CW'({1'b0, ca} - M_A) : ca;
      rb_q <= ({1'b0, cb} >= M_B) ? CW'({1'b0, cb} - M_B) : cb;
    end
  end

  assign done_o  = stg_q[2];
  assign rem_a_o = ra_q;
  assign rem_b_o = rb_q;

endmodule

`default_nettype wire

// ----- rtl/tfcr_walk.sv -----
// ----------------------------------------------------------------------------
// tfcr_walk
// walks the clipped bounding box of one disc a cell per cycle and issues
// the writes of the cells inside it
// ----------------------------------------------------------------------------
`default_nettype none

module tfcr_walk #(
  parameter int GRID_WIDTH  = tfcr_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = tfcr_pkg::GRID_HEIGHT_DEF,
  localparam int ADDR_W = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire tfcr_pkg::disc_t              disc_i,
  output logic                              idle_o,
  output logic                              wr_en_o,
  output logic      [ADDR_W-1:0]            wr_addr_o,
  output logic      [tfcr_pkg::VALUE_W-1:0] wr_data_o
);

  localparam int CNT_W  = tfcr_pkg::CNT_W;
  localparam int CEN_W  = tfcr_pkg::CEN_W;
  localparam int SPAN_W = tfcr_pkg::SPAN_W;
  localparam int PROD_W = tfcr_pkg::PROD_W;
  localparam int RW     = tfcr_pkg::RADIUS_W;
  localparam int FW     = tfcr_pkg::FRAC_W;
  localparam int SQ_W   = 2 * FW + 1;
  localparam int D2_W   = SQ_W + 1;
  localparam int R2_W   = 2 * RW;
  localparam int CMP_W  = D2_W + 2 * FW;

  localparam logic [CNT_W-1:0]  W_LIM = CNT_W'(GRID_WIDTH);
  localparam logic [CNT_W-1:0]  H_LIM = CNT_W'(GRID_HEIGHT);
  localparam logic [ADDR_W-1:0] W_ROW = ADDR_W'(GRID_WIDTH);

  localparam logic [1:0] WK_IDLE = 2'd0;
  localparam logic [1:0] WK_BASE = 2'd1;
  localparam logic [1:0] WK_RUN  = 2'd2;

  function automatic logic [CNT_W-1:0] clamp_span(input logic signed [SPAN_W-1:0] v,
                                                  input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({2'b00, lim})) begin
      res = lim;
    end else begin
      res = v[CNT_W-1:0];
    end
    return res;
  endfunction

  logic [1:0]              state_q;
  logic signed [CEN_W-1:0] cx_q, cy_q;
  logic [tfcr_pkg::VALUE_W-1:0] val_q;
  logic [R2_W-1:0]         r2_q;
  logic [CNT_W-1:0]        left_q, right_q, top_q, bot_q, i_q, j_q;
  logic [ADDR_W-1:0]       base_q;
  logic                    s1_v_q, wr_v_q;
  logic [ADDR_W-1:0]       s1_addr_q, wr_addr_q;
  logic [SQ_W-1:0]         s1_dx2_q, s1_dy2_q;

  logic [FW-1:0]           rfloor;
  logic [FW:0]             rceil;
  logic signed [SPAN_W-1:0] lv, rv, tv, bv;
  logic signed [SPAN_W-1:0] dx_full, dy_full;
  logic signed [2*FW+3:0]  sq_x, sq_y;
  logic [D2_W-1:0]         d2;
  logic                    hit, last_col, last_row, empty;
  logic [PROD_W-1:0]       base_prod;

  // bounding box: floor of radius to the right, ceiling to the left
  assign rfloor = disc_i.rq[RW-1:FW];
  assign rceil  = {1'b0, rfloor} + (FW+1)'(|disc_i.rq[FW-1:0]);
  assign lv = $signed({disc_i.cx[CEN_W-1], disc_i.cx}) - $signed({{(SPAN_W-FW-1){1'b0}}, rceil});
  assign rv = $signed({disc_i.cx[CEN_W-1], disc_i.cx})
            + $signed({{(SPAN_W-FW){1'b0}}, rfloor}) + SPAN_W'(1);
  assign tv = $signed({disc_i.cy[CEN_W-1], disc_i.cy}) - $signed({{(SPAN_W-FW-1){1'b0}}, rceil});
  assign bv = $signed({disc_i.cy[CEN_W-1], disc_i.cy})
            + $signed({{(SPAN_W-FW){1'b0}}, rfloor}) + SPAN_W'(1);

  assign empty     = (left_q >= right_q) || (top_q >= bot_q);
  assign base_prod = PROD_W'(top_q) * PROD_W'(GRID_WIDTH);
  assign last_col  = (i_q == right_q - CNT_W'(1));
  assign last_row  = (j_q == bot_q - CNT_W'(1));

  // offsets stay within the radius, so ten bits carry them
  assign dx_full = $signed({cx_q[CEN_W-1], cx_q}) - $signed({2'b00, i_q});
  assign dy_full = $signed({cy_q[CEN_W-1], cy_q}) - $signed({2'b00, j_q});
  assign sq_x    = $signed(dx_full[FW+1:0]) * $signed(dx_full[FW+1:0]);
  assign sq_y    = $signed(dy_full[FW+1:0]) * $signed(dy_full[FW+1:0]);

  assign d2  = {1'b0, s1_dx2_q} + {1'b0, s1_dy2_q};
  assign hit = {d2, {(2*FW){1'b0}}} < {{(CMP_W-R2_W){1'b0}}, r2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WK_IDLE;
      s1_v_q  <= 1'b0;
      wr_v_q  <= 1'b0;
    end else begin
      s1_v_q <= (state_q == WK_RUN);
      wr_v_q <= s1_v_q && hit;
      case (state_q)
        WK_IDLE: begin
          if (start_i) begin
            state_q <= WK_BASE;
          end
        end
        WK_BASE: begin
          state_q <= empty ? WK_IDLE : WK_RUN;
        end
        WK_RUN: begin
          if (last_col && last_row) begin
            state_q <= WK_IDLE;
          end
        end
        default: begin
          state_q <= WK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == WK_IDLE && start_i) begin
      cx_q    <= disc_i.cx;
      cy_q    <= disc_i.cy;
      val_q   <= disc_i.val;
      r2_q    <= R2_W'(disc_i.rq) * R2_W'(disc_i.rq);
      left_q  <= clamp_span(lv, W_LIM);
      right_q <= clamp_span(rv, W_LIM);
      top_q   <= clamp_span(tv, H_LIM);
      bot_q   <= clamp_span(bv, H_LIM);
    end
    if (state_q == WK_BASE) begin
      base_q <= base_prod[ADDR_W-1:0];
      i_q    <= left_q;
      j_q    <= top_q;
    end else if (state_q == WK_RUN) begin
      if (last_col) begin
        i_q    <= left_q;
        j_q    <= j_q + CNT_W'(1);
        base_q <= base_q + W_ROW;
      end else begin
        i_q <= i_q + CNT_W'(1);
      end
    end
    s1_addr_q <= base_q + ADDR_W'(i_q);
    s1_dx2_q  <= sq_x[SQ_W-1:0];
    s1_dy2_q  <= sq_y[SQ_W-1:0];
    wr_addr_q <= s1_addr_q;
  end

  assign idle_o    = (state_q == WK_IDLE) && !s1_v_q && !wr_v_q;
  assign wr_en_o   = wr_v_q;
  assign wr_addr_o = wr_addr_q;
  assign wr_data_o = val_q;

endmodule

`default_nettype wire

// ----- rtl/toroidal_filled_circle_raster.sv -----
// ----------------------------------------------------------------------------
// toroidal_filled_circle_raster
// grid of cells in one memory with clear, filled circle draw on a torus and
// single cell read commands
// ----------------------------------------------------------------------------
// clear: one memory write a cycle, sweeping every cell; read: coordinate reduction, then
//   address, memory read and result; draw: reduction and a nine-slot copy scan, then a walk
//   of the clipped box of each copy drawn
// throughput: one item at a time, busy stays high until its result shows; results are never
//   held off, the strobe lasts one cycle and the next item may start in it
// reset: control returns to idle at once, the grid memory holds anything until written
`default_nettype none

module toroidal_filled_circle_raster #(
  parameter int GRID_WIDTH  = tfcr_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = tfcr_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tfcr_pkg::OP_W-1:0]     opcode_i,
  input  wire logic [tfcr_pkg::COORD_W-1:0]  center_x_i,
  input  wire logic [tfcr_pkg::COORD_W-1:0]  center_y_i,
  input  wire logic [tfcr_pkg::RADIUS_W-1:0] radius_q_i,
  input  wire logic [tfcr_pkg::VALUE_W-1:0]  color_value_i,
  input  wire logic [tfcr_pkg::READ_W-1:0]   read_x_i,
  input  wire logic [tfcr_pkg::READ_W-1:0]   read_y_i,
  output logic                               result_valid_o,
  output logic      [tfcr_pkg::VALUE_W-1:0]  read_value_o,
  output logic                               done_res_o
);

  localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CW     = tfcr_pkg::COORD_W;
  localparam int CEN_W  = tfcr_pkg::CEN_W;
  localparam int PROD_W = tfcr_pkg::PROD_W;
  localparam int RW     = tfcr_pkg::RADIUS_W;
  localparam int VW     = tfcr_pkg::VALUE_W;
  localparam int FW     = tfcr_pkg::FRAC_W;
  localparam int COPY_W = tfcr_pkg::COPY_W;
  localparam int EDGE_W = CW + FW + 1;

  localparam logic [ADDR_W-1:0]      LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic signed [CEN_W-1:0] W_S      = CEN_W'(GRID_WIDTH);
  localparam logic signed [CEN_W-1:0] H_S      = CEN_W'(GRID_HEIGHT);
  localparam logic [EDGE_W-1:0]      W_EDGE    = EDGE_W'(GRID_WIDTH * (2 ** FW));
  localparam logic [EDGE_W-1:0]      H_EDGE    = EDGE_W'(GRID_HEIGHT * (2 ** FW));
  localparam logic [EDGE_W-1:0]      ONE_CELL  = EDGE_W'(2 ** FW);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_RREQ  = 3'd5;
  localparam logic [2:0] ST_RDATA = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [tfcr_pkg::OP_W-1:0]   op_q, op_d;
  logic [VW-1:0]               val_q, val_d;
  logic [RW-1:0]               rq_q, rq_d;
  logic                        lox_q, lox_d, hix_q, hix_d, loy_q, loy_d, hiy_q, hiy_d;
  logic [COPY_W-1:0]           a_q, a_d, b_q, b_d;
  logic [ADDR_W-1:0]           clr_q, clr_d, rd_addr_q, rd_addr_d;
  logic                        res_v_q, res_v_d;
  logic [VW-1:0]               res_val_q, res_val_d;

  logic                        mod_start, mod_done;
  logic [CW-1:0]               mod_x_in, mod_rx, mod_ry;
  logic                        wk_start, wk_idle, wk_we;
  logic [ADDR_W-1:0]           wk_addr, ram_waddr;
  logic [VW-1:0]               wk_data, ram_wdata, ram_rdata;
  logic                        clr_we, ram_we, ram_re, adv;
  logic                        use_x, use_y, last_copy;
  logic signed [CEN_W-1:0]     nx, ny;
  logic [PROD_W-1:0]           rd_prod;
  tfcr_pkg::disc_t             disc;

  // read coordinates share the reduction unit with draw centres
  assign mod_x_in = (opcode_i == tfcr_pkg::OP_READ) ? CW'(read_x_i) : center_x_i;

  tfcr_modred #(
    .MOD_A (GRID_WIDTH),
    .MOD_B (GRID_HEIGHT)
  ) u_modred (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .a_i     (mod_x_in),
    .b_i     ((opcode_i == tfcr_pkg::OP_READ) ? CW'(read_y_i) : center_y_i),
    .done_o  (mod_done),
    .rem_a_o (mod_rx),
    .rem_b_o (mod_ry)
  );

  // which wrapped copy is under consideration, and its centre
  assign use_x = (a_q == tfcr_pkg::COPY_BASE) || (a_q == tfcr_pkg::COPY_LO && lox_q)
              || (a_q == tfcr_pkg::COPY_HI && hix_q);
  assign use_y = (b_q == tfcr_pkg::COPY_BASE) || (b_q == tfcr_pkg::COPY_LO && loy_q)
              || (b_q == tfcr_pkg::COPY_HI && hiy_q);
  assign last_copy = (a_q == tfcr_pkg::COPY_HI) && (b_q == tfcr_pkg::COPY_HI);

  assign nx = $signed({2'b00, mod_rx}) + ((a_q == tfcr_pkg::COPY_LO) ? W_S : '0)
            - ((a_q == tfcr_pkg::COPY_HI) ? W_S : '0);
  assign ny = $signed({2'b00, mod_ry}) + ((b_q == tfcr_pkg::COPY_LO) ? H_S : '0)
            - ((b_q == tfcr_pkg::COPY_HI) ? H_S : '0);

  assign disc.cx  = nx;
  assign disc.cy  = ny;
  assign disc.rq  = rq_q;
  assign disc.val = val_q;

  tfcr_walk #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (wk_start),
    .disc_i    (disc),
    .idle_o    (wk_idle),
    .wr_en_o   (wk_we),
    .wr_addr_o (wk_addr),
    .wr_data_o (wk_data)
  );

  // row-major address of the reduced read coordinate
  assign rd_prod = PROD_W'(mod_ry) * PROD_W'(GRID_WIDTH) + PROD_W'(mod_rx);

  // sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    val_d     = val_q;
    rq_d      = rq_q;
    lox_d     = lox_q;
    hix_d     = hix_q;
    loy_d     = loy_q;
    hiy_d     = hiy_q;
    a_d       = a_q;
    b_d       = b_q;
    clr_d     = clr_q;
    rd_addr_d = rd_addr_q;
    res_v_d   = 1'b0;
    res_val_d = res_val_q;
    mod_start = 1'b0;
    wk_start  = 1'b0;
    clr_we    = 1'b0;
    ram_re    = 1'b0;
    adv       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d  = opcode_i;
          val_d = color_value_i;
          rq_d  = radius_q_i;
          if (opcode_i == tfcr_pkg::OP_CLEAR) begin
            clr_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            mod_start = 1'b1;
            state_d   = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          if (op_q == tfcr_pkg::OP_DRAW) begin
            // a copy across an edge is needed when the radius reaches past it
            lox_d = {1'b0, mod_rx, {FW{1'b0}}} < EDGE_W'(rq_q);
            hix_d = ({1'b0, mod_rx, {FW{1'b0}}} + ONE_CELL + EDGE_W'(rq_q)) > W_EDGE;
            loy_d = {1'b0, mod_ry, {FW{1'b0}}} < EDGE_W'(rq_q);
            hiy_d = ({1'b0, mod_ry, {FW{1'b0}}} + ONE_CELL + EDGE_W'(rq_q)) > H_EDGE;
            a_d     = tfcr_pkg::COPY_BASE;
            b_d     = tfcr_pkg::COPY_BASE;
            state_d = ST_COPY;
          end else if (op_q == tfcr_pkg::OP_READ) begin
            rd_addr_d = rd_prod[ADDR_W-1:0];
            state_d   = ST_RREQ;
          end else begin
            // unused opcode: no memory access, just a zero result
            res_v_d   = 1'b1;
            res_val_d = '0;
            state_d   = ST_IDLE;
          end
        end
      end
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (clr_q == LAST_CELL) begin
          res_v_d   = 1'b1;
          res_val_d = '0;
          state_d   = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      ST_COPY: begin
        if (use_x && use_y) begin
          wk_start = 1'b1;
          state_d  = ST_WAIT;
        end else begin
          adv = 1'b1;
        end
      end
      ST_WAIT: begin
        // walker idle means its last write has reached the memory
        if (wk_idle) begin
          adv = 1'b1;
        end
      end
      ST_RREQ: begin
        ram_re  = 1'b1;
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        res_v_d   = 1'b1;
        res_val_d = ram_rdata;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // step to the next copy, columns outer and rows inner
    if (adv) begin
      if (last_copy) begin
        res_v_d   = 1'b1;
        res_val_d = '0;
        state_d   = ST_IDLE;
      end else begin
        state_d = ST_COPY;
        if (b_q == tfcr_pkg::COPY_HI) begin
          b_d = tfcr_pkg::COPY_BASE;
          a_d = a_q + COPY_W'(1);
        end else begin
          b_d = b_q + COPY_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    rq_q      <= rq_d;
    lox_q     <= lox_d;
    hix_q     <= hix_d;
    loy_q     <= loy_d;
    hiy_q     <= hiy_d;
    a_q       <= a_d;
    b_q       <= b_d;
    clr_q     <= clr_d;
    rd_addr_q <= rd_addr_d;
    res_val_q <= res_val_d;
  end

  // grid memory: clear sweep or walker writes, one read port
  assign ram_we    = clr_we || wk_we;
  assign ram_waddr = clr_we ? clr_q : wk_addr;
  assign ram_wdata = clr_we ? val_q : wk_data;

  tfcr_ram #(
    .WIDTH (VW),
    .DEPTH (CELLS)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_v_q;
  assign done_res_o     = res_v_q;
  assign read_value_o   = res_val_q;

endmodule

`default_nettype wire

// ----- rtl/tfcr_checker.sv -----
// ----------------------------------------------------------------------------
// tfcr_checker
// port level checks of the command handshake and result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module tfcr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_i,
  input wire logic res_valid_i,
  input wire logic done_res_i
);

  // an accepted item always keeps the block busy for a while
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("accepted item did not raise busy");

  // busy only drops together with the result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> res_valid_i)
    else $error("busy fell without a result");

  // one result per item, so no strobe on consecutive cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |=> !res_valid_i)
    else $error("result strobe held for two cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> done_res_i && !busy_i)
    else $error("result shown without completion");

endmodule

bind toroidal_filled_circle_raster tfcr_checker u_tfcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .res_valid_i (result_valid_o),
  .done_res_i  (done_res_o)
);

`default_nettype wire
